[hw/rtl/dwc_pkg.sv]
package dwc_pkg;

	// field widths
	localparam int unsigned UTC_W  = 32;
	localparam int unsigned YEAR_W = 12;
	localparam int unsigned SEC_W  = 33;
	localparam int unsigned ZONE_W = 17;
	localparam int unsigned DAY_W  = 16;
	localparam int unsigned DOY_W  = 9;
	localparam int unsigned WD_W   = 3;
	localparam int unsigned SDAY_W = 17;
	localparam int unsigned PROD_W = 34;

	// calendar constants
	localparam logic [YEAR_W-1:0] EPOCH_YEAR    = 12'd1970;
	localparam logic [YEAR_W-1:0] NONLEAP_100   = 12'd2100;
	localparam logic [WD_W-1:0]   EPOCH_WD      = 3'd4;
	localparam logic [UTC_W-1:0]  YEAR_SEC      = 32'd31536000;
	localparam logic [UTC_W-1:0]  LEAP_YEAR_SEC = 32'd31622400;
	localparam logic [DAY_W-1:0]  YEAR_DAYS     = 16'd365;
	localparam logic [DAY_W-1:0]  LEAP_DAYS     = 16'd366;
	localparam logic [SDAY_W-1:0] SEC_DAY       = 17'd86400;
	localparam logic [ZONE_W-1:0] SEC_HOUR      = 17'd3600;
	localparam logic [ZONE_W-1:0] SEC_2HOUR     = 17'd7200;

	// day of year (from 0) of the first of a month, common year
	localparam logic [DOY_W-1:0] MAR1_DOY = 9'd59;
	localparam logic [DOY_W-1:0] OCT1_DOY = 9'd273;
	localparam logic [DOY_W-1:0] NOV1_DOY = 9'd304;
	localparam logic [DOY_W-1:0] WEEK_DAYS = 9'd7;
	localparam logic [DOY_W-1:0] LAST_OFS = 9'd30;

	// weekday shift of the first of a month against 1 january, common year
	localparam logic [WD_W-1:0] MAR1_WD   = 3'd3;
	localparam logic [WD_W-1:0] OCT1_WD   = 3'd0;
	localparam logic [WD_W-1:0] NOV1_WD   = 3'd3;
	localparam logic [WD_W-1:0] DAY31_WD  = 3'd2;
	localparam logic [WD_W-1:0] WD_ONE    = 3'd1;
	localparam logic [WD_W-1:0] WD_TWO    = 3'd2;
	localparam logic [WD_W:0]   WD_MOD    = 4'd7;

	// zone offset ranges of the rule sets
	localparam logic signed [ZONE_W-1:0] US_TZ_MIN = -17'sd28800;
	localparam logic signed [ZONE_W-1:0] US_TZ_MAX = -17'sd14400;
	localparam logic signed [ZONE_W-1:0] EU_TZ_MIN = 17'sd0;
	localparam logic signed [ZONE_W-1:0] EU_TZ_MAX = 17'sd7200;

	typedef enum logic {
		RULE_US = 1'b0,
		RULE_EU = 1'b1
	} dwc_rule_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_YEAR,
		ST_START_DATE,
		ST_START_MUL,
		ST_END_DATE,
		ST_END_MUL,
		ST_OUT
	} dwc_state_t;

	typedef struct packed {
		logic load;
		logic year_step;
		logic start_date;
		logic start_mul;
		logic end_date;
		logic end_mul;
		logic next_year;
	} dwc_cmd_t;

	typedef struct packed {
		logic year_done;
		logic rule_ok;
		logic last;
	} dwc_sts_t;

	// leap year test, exact over 1970 to 2107 (2000 leap, 2100 not)
	function automatic logic is_leap(input logic [YEAR_W-1:0] y);
		return (y[1:0] == 2'b00) && (y != NONLEAP_100);
	endfunction

	// weekday sum modulo 7, operands 0 to 6
	function automatic logic [WD_W-1:0] wd_add(input logic [WD_W-1:0] a,
		input logic [WD_W-1:0] b);
		logic [WD_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= WD_MOD) begin
			s = s - WD_MOD;
		end
		return s[WD_W-1:0];
	endfunction

	// days forward from a weekday to the next sunday, zero on a sunday
	function automatic logic [DOY_W-1:0] to_sunday(input logic [WD_W-1:0] w);
		logic [DOY_W-1:0] d;
		d = '0;
		if (w != '0) begin
			d = WEEK_DAYS - DOY_W'(w);
		end
		return d;
	endfunction

endpackage

[hw/rtl/dwc_stamp_if.sv]
interface dwc_stamp_if;
	logic                          valid;
	logic                          ready;
	logic [dwc_pkg::UTC_W-1:0]     utc_seconds;

	modport source (output valid, output utc_seconds, input ready);
	modport sink (input valid, input utc_seconds, output ready);
endinterface

[hw/rtl/dwc_window_if.sv]
interface dwc_window_if;
	logic                          valid;
	logic                          ready;
	logic [dwc_pkg::YEAR_W-1:0]    window_year;
	logic [dwc_pkg::SEC_W-1:0]     window_start;
	logic [dwc_pkg::SEC_W-1:0]     window_end;
	logic                          rule_set;
	logic                          is_last;

	modport source (output valid, output window_year, output window_start,
		output window_end, output rule_set, output is_last, input ready);
	modport sink (input valid, input window_year, input window_start,
		input window_end, input rule_set, input is_last, output ready);
endinterface

[hw/rtl/dwc_cfg_if.sv]
interface dwc_cfg_if;
	logic                                valid;
	logic                                ready;
	logic signed [dwc_pkg::ZONE_W-1:0]   zone_offset_seconds;

	modport source (output valid, output zone_offset_seconds, input ready);
	modport sink (input valid, input zone_offset_seconds, output ready);
endinterface

[hw/rtl/dst_window_calculator.sv]
// Daylight saving window calculator. A request on stamp carries a UTC Unix time; the block
// finds its calendar year and returns two results on window, the daylight window of that
// year and of the next, start and end in UTC seconds. The zone offset written on cfg picks
// US rules (-8h to -4h) or EU rules (0 to +2h); any other offset consumes the request and
// returns nothing. Requests are taken one at a time, only while no result is pending. The
// year search subtracts one year per cycle from 1970; each window then takes a day count and
// one 16x17 multiply for the start, the same for the end, then output.
// Write cfg only while the block is idle.
module dst_window_calculator (
	input  logic        clk,
	input  logic        arst_n,
	dwc_cfg_if.sink     cfg,
	dwc_stamp_if.sink   stamp,
	dwc_window_if.source window
);

	dwc_pkg::dwc_cmd_t cmd;
	dwc_pkg::dwc_sts_t sts;

	// sequencer
	dwc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.stamp_valid  (stamp.valid),
		.stamp_ready  (stamp.ready),
		.window_valid (window.valid),
		.window_ready (window.ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	// calendar arithmetic
	dwc_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.utc_seconds  (stamp.utc_seconds),
		.cmd          (cmd),
		.sts          (sts),
		.window_year  (window.window_year),
		.window_start (window.window_start),
		.window_end   (window.window_end),
		.rule_set     (window.rule_set),
		.is_last      (window.is_last)
	);

endmodule

[hw/rtl/dwc_ctrl.sv]
module dwc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              stamp_valid,
	output logic              stamp_ready,
	output logic              window_valid,
	input  logic              window_ready,
	input  dwc_pkg::dwc_sts_t sts,
	output dwc_pkg::dwc_cmd_t cmd
);

	dwc_pkg::dwc_state_t state_q;
	dwc_pkg::dwc_state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dwc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dwc_pkg::ST_IDLE: begin
				if (stamp_valid && sts.rule_ok) begin
					state_d = dwc_pkg::ST_YEAR;
				end
			end
			dwc_pkg::ST_YEAR: begin
				if (sts.year_done) begin
					state_d = dwc_pkg::ST_START_DATE;
				end
			end
			dwc_pkg::ST_START_DATE: state_d = dwc_pkg::ST_START_MUL;
			dwc_pkg::ST_START_MUL:  state_d = dwc_pkg::ST_END_DATE;
			dwc_pkg::ST_END_DATE:   state_d = dwc_pkg::ST_END_MUL;
			dwc_pkg::ST_END_MUL:    state_d = dwc_pkg::ST_OUT;
			dwc_pkg::ST_OUT: begin
				if (window_ready) begin
					state_d = sts.last ? dwc_pkg::ST_IDLE : dwc_pkg::ST_START_DATE;
				end
			end
			default: state_d = dwc_pkg::ST_IDLE;
		endcase
	end

	// commands and handshake outputs
	always_comb begin
		cmd          = '0;
		stamp_ready  = 1'b0;
		window_valid = 1'b0;
		unique case (state_q)
			dwc_pkg::ST_IDLE: begin
				stamp_ready = 1'b1;
				cmd.load    = stamp_valid && sts.rule_ok;
			end
			dwc_pkg::ST_YEAR:       cmd.year_step  = 1'b1;
			dwc_pkg::ST_START_DATE: cmd.start_date = 1'b1;
			dwc_pkg::ST_START_MUL:  cmd.start_mul  = 1'b1;
			dwc_pkg::ST_END_DATE:   cmd.end_date   = 1'b1;
			dwc_pkg::ST_END_MUL:    cmd.end_mul    = 1'b1;
			dwc_pkg::ST_OUT: begin
				window_valid  = 1'b1;
				cmd.next_year = window_ready && !sts.last;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

[hw/rtl/dwc_datapath.sv]
module dwc_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	dwc_cfg_if.sink                        cfg,
	input  logic [dwc_pkg::UTC_W-1:0]      utc_seconds,
	input  dwc_pkg::dwc_cmd_t              cmd,
	output dwc_pkg::dwc_sts_t              sts,
	output logic [dwc_pkg::YEAR_W-1:0]     window_year,
	output logic [dwc_pkg::SEC_W-1:0]      window_start,
	output logic [dwc_pkg::SEC_W-1:0]      window_end,
	output logic                           rule_set,
	output logic                           is_last
);

	logic signed [dwc_pkg::ZONE_W-1:0] zone_q;
	logic signed [dwc_pkg::ZONE_W-1:0] tz_q;
	logic [dwc_pkg::UTC_W-1:0]         rem_q;
	logic [dwc_pkg::YEAR_W-1:0]        year_q;
	logic [dwc_pkg::DAY_W-1:0]         days_q;
	logic [dwc_pkg::WD_W-1:0]          wd_q;
	logic [dwc_pkg::DAY_W-1:0]         day_q;
	logic [dwc_pkg::SEC_W-1:0]         start_q;
	logic [dwc_pkg::SEC_W-1:0]         end_q;
	dwc_pkg::dwc_rule_t                rule_q;
	logic                              last_q;

	logic                              leap;
	logic                              rule_us;
	logic                              rule_eu;
	logic [dwc_pkg::UTC_W-1:0]         ylen_sec;
	logic                              year_done;
	logic [dwc_pkg::WD_W-1:0]          wd_mar1;
	logic [dwc_pkg::WD_W-1:0]          wd_oct1;
	logic [dwc_pkg::WD_W-1:0]          wd_nov1;
	logic [dwc_pkg::DOY_W-1:0]         start_doy;
	logic [dwc_pkg::DOY_W-1:0]         end_doy;
	logic [dwc_pkg::ZONE_W-1:0]        start_add;
	logic [dwc_pkg::ZONE_W-1:0]        end_add;
	logic [dwc_pkg::PROD_W-1:0]        prod;
	logic [dwc_pkg::PROD_W-1:0]        start_sum;
	logic [dwc_pkg::PROD_W-1:0]        end_sum;

	assign cfg.ready = 1'b1;

	// zone offset register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q <= '0;
		end else if (cfg.valid) begin
			zone_q <= cfg.zone_offset_seconds;
		end
	end

	// rule selection from the zone offset
	assign rule_us = (zone_q >= dwc_pkg::US_TZ_MIN) && (zone_q <= dwc_pkg::US_TZ_MAX);
	assign rule_eu = (zone_q >= dwc_pkg::EU_TZ_MIN) && (zone_q <= dwc_pkg::EU_TZ_MAX);

	// year length and year search end
	assign leap      = dwc_pkg::is_leap(year_q);
	assign ylen_sec  = leap ? dwc_pkg::LEAP_YEAR_SEC : dwc_pkg::YEAR_SEC;
	assign year_done = rem_q < ylen_sec;

	// weekday of the first of march, october and november
	assign wd_oct1 = dwc_pkg::wd_add(wd_q, {{(dwc_pkg::WD_W-1){1'b0}}, leap});
	assign wd_mar1 = dwc_pkg::wd_add(wd_oct1, dwc_pkg::MAR1_WD);
	assign wd_nov1 = dwc_pkg::wd_add(wd_oct1, dwc_pkg::NOV1_WD - dwc_pkg::OCT1_WD);

	// day of year of the transition days
	always_comb begin
		if (rule_q == dwc_pkg::RULE_US) begin
			start_doy = dwc_pkg::MAR1_DOY + dwc_pkg::DOY_W'(leap)
				+ dwc_pkg::to_sunday(wd_mar1) + dwc_pkg::WEEK_DAYS;
			end_doy   = dwc_pkg::NOV1_DOY + dwc_pkg::DOY_W'(leap)
				+ dwc_pkg::to_sunday(wd_nov1);
			start_add = dwc_pkg::SEC_2HOUR - $unsigned(tz_q);
			end_add   = dwc_pkg::SEC_HOUR - $unsigned(tz_q);
		end else begin
			start_doy = dwc_pkg::MAR1_DOY + dwc_pkg::DOY_W'(leap) + dwc_pkg::LAST_OFS
				- dwc_pkg::DOY_W'(dwc_pkg::wd_add(wd_mar1, dwc_pkg::DAY31_WD));
			end_doy   = dwc_pkg::OCT1_DOY + dwc_pkg::DOY_W'(leap) + dwc_pkg::LAST_OFS
				- dwc_pkg::DOY_W'(dwc_pkg::wd_add(wd_oct1, dwc_pkg::DAY31_WD));
			start_add = dwc_pkg::SEC_HOUR;
			end_add   = dwc_pkg::SEC_HOUR;
		end
	end

	// day number to seconds
	assign prod      = dwc_pkg::PROD_W'(day_q) * dwc_pkg::PROD_W'(dwc_pkg::SEC_DAY);
	assign start_sum = prod + dwc_pkg::PROD_W'(start_add);
	assign end_sum   = prod + dwc_pkg::PROD_W'(end_add);

	// sequencing flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= 1'b0;
		end else if (cmd.load) begin
			last_q <= 1'b0;
		end else if (cmd.next_year) begin
			last_q <= 1'b1;
		end
	end

	// year search and window datapath
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q  <= utc_seconds;
			year_q <= dwc_pkg::EPOCH_YEAR;
			days_q <= '0;
			wd_q   <= dwc_pkg::EPOCH_WD;
			tz_q   <= zone_q;
			rule_q <= rule_eu ? dwc_pkg::RULE_EU : dwc_pkg::RULE_US;
		end else if ((cmd.year_step && !year_done) || cmd.next_year) begin
			if (cmd.year_step) begin
				rem_q <= rem_q - ylen_sec;
			end
			year_q <= year_q + dwc_pkg::YEAR_W'(1);
			days_q <= days_q + (leap ? dwc_pkg::LEAP_DAYS : dwc_pkg::YEAR_DAYS);
			wd_q   <= dwc_pkg::wd_add(wd_q, leap ? dwc_pkg::WD_TWO : dwc_pkg::WD_ONE);
		end
		if (cmd.start_date) begin
			day_q <= days_q + dwc_pkg::DAY_W'(start_doy);
		end else if (cmd.end_date) begin
			day_q <= days_q + dwc_pkg::DAY_W'(end_doy);
		end
		if (cmd.start_mul) begin
			start_q <= start_sum[dwc_pkg::SEC_W-1:0];
		end
		if (cmd.end_mul) begin
			end_q <= end_sum[dwc_pkg::SEC_W-1:0];
		end
	end

	assign sts.year_done = year_done;
	assign sts.rule_ok   = rule_us || rule_eu;
	assign sts.last      = last_q;

	assign window_year  = year_q;
	assign window_start = start_q;
	assign window_end   = end_q;
	assign rule_set     = rule_q;
	assign is_last      = last_q;

endmodule

[hw/rtl/dwc_checker.sv]
module dwc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          stamp_ready,
	input logic                          window_valid,
	input logic                          window_ready,
	input logic [dwc_pkg::YEAR_W-1:0]    window_year,
	input logic [dwc_pkg::SEC_W-1:0]     window_start,
	input logic [dwc_pkg::SEC_W-1:0]     window_end,
	input logic                          is_last
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		window_valid && !window_ready |=> window_valid && $stable(window_start)
			&& $stable(window_end) && $stable(window_year))
		else $error("stalled window changed");

	// no new request taken while a result is pending
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(stamp_ready && window_valid))
		else $error("request taken while window pending");

	// daylight starts before it ends
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		window_valid |-> window_start < window_end)
		else $error("window start not before end");

	// second window follows the first one year later
	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		window_valid && window_ready && !is_last |=> !window_valid
			&& window_year == $past(window_year) + dwc_pkg::YEAR_W'(1))
		else $error("next year window out of sequence");

endmodule

bind dst_window_calculator dwc_checker u_dwc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.stamp_ready  (stamp.ready),
	.window_valid (window.valid),
	.window_ready (window.ready),
	.window_year  (window.window_year),
	.window_start (window.window_start),
	.window_end   (window.window_end),
	.is_last      (window.is_last)
);

[verif/dst_window_calculator_tb.sv]
`timescale 1ns / 100ps

module dst_window_calculator_tb;

	localparam int CLK_HALF      = 6;
	localparam int RESET_CYCLES  = 6;
	localparam int SETTLE_CYCLES = 300;
	localparam int CYCLE_LIMIT   = 3000000;
	localparam int REPORT_MAX    = 10;
	localparam int PHASES        = 14;
	localparam int PHASE_STAMPS  = 100;

	localparam int DAY_SECONDS   = 86400;
	localparam int HOUR_SECONDS  = 3600;
	localparam int FIRST_YEAR    = 1970;
	localparam int LAST_YEAR     = 2106;
	localparam int EPOCH_WEEKDAY = 4; // 1 january 1970 fell on a thursday
	localparam int MARCH         = 3;
	localparam int OCTOBER       = 10;
	localparam int NOVEMBER      = 11;
	localparam int MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	localparam int US_ZONE_LO = -8 * HOUR_SECONDS;
	localparam int US_ZONE_HI = -4 * HOUR_SECONDS;
	localparam int EU_ZONE_LO = 0;
	localparam int EU_ZONE_HI = 2 * HOUR_SECONDS;
	localparam int ZONE_MIN   = -(1 << (dwc_pkg::ZONE_W - 1));
	localparam int ZONE_MAX   = (1 << (dwc_pkg::ZONE_W - 1)) - 1;

	typedef struct packed {
		logic [dwc_pkg::YEAR_W-1:0] year;
		logic [dwc_pkg::SEC_W-1:0]  win_start;
		logic [dwc_pkg::SEC_W-1:0]  win_end;
		dwc_pkg::dwc_rule_t         rule;
		logic                       is_last;
	} window_t;

	logic clk = 1'b0;
	logic arst_n;

	dwc_cfg_if    cfg_bus ();
	dwc_stamp_if  stamp_bus ();
	dwc_window_if window_bus ();

	dst_window_calculator i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.stamp  (stamp_bus),
		.window (window_bus)
	);

	window_t pending_windows [$];
	int      cur_zone;
	int      stamp_gap;
	bit      quiet;
	int      cycle_count = 0;
	int      mismatches = 0;
	int      windows_checked = 0;
	int      stamps_sent;
	int      zone_writes;

	// clock
	always #CLK_HALF clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// calendar arithmetic for the window predictor
	function automatic bit leap_year(input int y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int month_length(input int y, input int m);
		if (m == 2 && leap_year(y)) begin
			return 29;
		end
		return MONTH_LEN[m - 1];
	endfunction

	// days from 1 january 1970 to the given date
	function automatic longint day_index(input int y, input int m, input int d);
		longint days;
		days = 0;
		for (int k = FIRST_YEAR; k < y; k++) begin
			days += leap_year(k) ? 366 : 365;
		end
		for (int k = 1; k < m; k++) begin
			days += month_length(y, k);
		end
		return days + d - 1;
	endfunction

	// 0 sunday to 6 saturday
	function automatic int week_day_of(input longint days);
		return int'((days + EPOCH_WEEKDAY) % 7);
	endfunction

	function automatic int nth_sunday_of(input int y, input int m, input int n);
		int wd;
		wd = week_day_of(day_index(y, m, 1));
		return 1 + (7 - wd) % 7 + 7 * (n - 1);
	endfunction

	function automatic int last_sunday_of(input int y, input int m);
		int len;
		len = month_length(y, m);
		return len - week_day_of(day_index(y, m, len));
	endfunction

	// queue the two daylight windows that one request should produce
	task automatic predict_windows(input logic [dwc_pkg::UTC_W-1:0] utc, input int zone);
		longint             rem;
		int                 base_year;
		longint             year_len;
		longint             s;
		longint             e;
		int                 y;
		dwc_pkg::dwc_rule_t rule;
		window_t            w;
		rem = longint'(utc);
		base_year = FIRST_YEAR;
		forever begin
			year_len = (leap_year(base_year) ? 366 : 365) * longint'(DAY_SECONDS);
			if (rem < year_len) begin
				break;
			end
			rem -= year_len;
			base_year++;
		end
		// offsets outside both rule ranges consume the request silently
		if (zone >= US_ZONE_LO && zone <= US_ZONE_HI) begin
			rule = dwc_pkg::RULE_US;
		end else if (zone >= EU_ZONE_LO && zone <= EU_ZONE_HI) begin
			rule = dwc_pkg::RULE_EU;
		end else begin
			return;
		end
		for (int k = 0; k < 2; k++) begin
			y = base_year + k;
			if (rule == dwc_pkg::RULE_US) begin
				s = day_index(y, MARCH, nth_sunday_of(y, MARCH, 2)) * DAY_SECONDS
					+ 2 * HOUR_SECONDS - zone;
				e = day_index(y, NOVEMBER, nth_sunday_of(y, NOVEMBER, 1)) * DAY_SECONDS
					+ HOUR_SECONDS - zone;
			end else begin
				s = day_index(y, MARCH, last_sunday_of(y, MARCH)) * DAY_SECONDS
					+ HOUR_SECONDS;
				e = day_index(y, OCTOBER, last_sunday_of(y, OCTOBER)) * DAY_SECONDS
					+ HOUR_SECONDS;
			end
			w.year      = dwc_pkg::YEAR_W'(y);
			w.win_start = dwc_pkg::SEC_W'(s);
			w.win_end   = dwc_pkg::SEC_W'(e);
			w.rule      = rule;
			w.is_last   = (k == 1);
			pending_windows.push_back(w);
		end
	endtask

	// idle length: mostly none or short, now and then long
	function automatic int pick_idle();
		int r;
		if (quiet) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// one time stamp request, predicted at the edge where it is taken
	task automatic send_stamp(input logic [dwc_pkg::UTC_W-1:0] utc);
		if (stamp_gap > 0) begin
			repeat (stamp_gap) @(posedge clk);
		end
		stamp_bus.valid       <= 1'b1;
		stamp_bus.utc_seconds <= utc;
		@(posedge clk);
		while (!stamp_bus.ready) begin
			@(posedge clk);
		end
		predict_windows(utc, cur_zone);
		stamps_sent++;
		stamp_gap = pick_idle();
		if (stamp_gap > 0) begin
			stamp_bus.valid <= 1'b0;
		end
	endtask

	// drop valid after the last request of a run of requests
	task automatic stamp_release();
		if (stamp_gap == 0) begin
			stamp_bus.valid <= 1'b0;
			stamp_gap = 1;
		end
	endtask

	// zone offset write, only once the block has drained
	task automatic write_zone(input int zone);
		logic signed [dwc_pkg::ZONE_W-1:0] v;
		stamp_release();
		v = zone[dwc_pkg::ZONE_W-1:0];
		while (pending_windows.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_bus.valid               <= 1'b1;
		cfg_bus.zone_offset_seconds <= v;
		@(posedge clk);
		while (!cfg_bus.ready) begin
			@(posedge clk);
		end
		cfg_bus.valid <= 1'b0;
		cur_zone = v;
		zone_writes++;
	endtask

	function automatic int random_zone();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4) begin
			return US_ZONE_LO + int'($urandom_range(0, US_ZONE_HI - US_ZONE_LO));
		end else if (r < 8) begin
			return int'($urandom_range(EU_ZONE_LO, EU_ZONE_HI));
		end else if (r == 8) begin
			case ($urandom_range(0, 3))
				0: return US_ZONE_LO;
				1: return US_ZONE_HI;
				2: return EU_ZONE_LO;
				default: return EU_ZONE_HI;
			endcase
		end
		// any 17-bit pattern, in range or not
		return int'($urandom_range(0, ZONE_MAX - ZONE_MIN)) + ZONE_MIN;
	endfunction

	function automatic logic [dwc_pkg::UTC_W-1:0] random_stamp();
		int     r;
		int     y;
		longint t;
		r = $urandom_range(0, 9);
		if (r < 5) begin
			return $urandom;
		end else if (r < 7) begin
			// a couple of seconds either side of new year
			y = $urandom_range(FIRST_YEAR + 1, LAST_YEAR);
			t = day_index(y, 1, 1) * DAY_SECONDS + longint'($urandom_range(0, 4)) - 2;
			return dwc_pkg::UTC_W'(t);
		end else if (r == 7) begin
			return $urandom_range(0, 6 * 31536000);
		end else if (r == 8) begin
			return $urandom_range(32'hF000_0000, 32'hFFFF_FFFF);
		end
		case ($urandom_range(0, 3))
			0: return '0;
			1: return dwc_pkg::UTC_W'(1);
			2: return {{(dwc_pkg::UTC_W-1){1'b1}}, 1'b0};
			default: return '1;
		endcase
	endfunction

	// result stalls
	initial begin : result_stall
		int s;
		window_bus.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) begin
			@(posedge clk);
		end
		forever begin
			s = pick_idle();
			if (s > 0) begin
				window_bus.ready <= 1'b0;
				repeat (s) @(posedge clk);
			end
			window_bus.ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// window checker
	always @(posedge clk) begin
		window_t got;
		window_t want;
		if (arst_n && window_bus.valid && window_bus.ready) begin
			got.year      = window_bus.window_year;
			got.win_start = window_bus.window_start;
			got.win_end   = window_bus.window_end;
			got.rule      = dwc_pkg::dwc_rule_t'(window_bus.rule_set);
			got.is_last   = window_bus.is_last;
			if (pending_windows.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display("unexpected window: year %0d start %0d end %0d rule %0d last %0d",
						got.year, got.win_start, got.win_end, got.rule, got.is_last);
				end
			end else begin
				want = pending_windows.pop_front();
				windows_checked++;
				if (got.year !== want.year || got.win_start !== want.win_start
						|| got.win_end !== want.win_end || got.rule !== want.rule
						|| got.is_last !== want.is_last) begin
					mismatches++;
					if (mismatches <= REPORT_MAX) begin
						$display("window mismatch: expected year %0d start %0d end %0d rule %0d last %0d",
							want.year, want.win_start, want.win_end, want.rule, want.is_last);
						$display("                 actual   year %0d start %0d end %0d rule %0d last %0d",
							got.year, got.win_start, got.win_end, got.rule, got.is_last);
					end
				end
			end
		end
	end

	// us offsets at both ends of the range, year edges and leap days
	task automatic test_us_rules();
		write_zone(US_ZONE_LO);
		send_stamp('0);
		send_stamp('1);
		send_stamp(32'd951782400);  // 29 february 2000
		write_zone(US_ZONE_HI);
		send_stamp(32'd31535999);   // last second of 1970
		send_stamp(32'd31536000);
		write_zone(-5 * HOUR_SECONDS);
		send_stamp(32'd1710054000); // on a march transition
	endtask

	// eu offsets, including the 2100 non-leap century
	task automatic test_eu_rules();
		write_zone(EU_ZONE_LO);
		send_stamp('0);
		send_stamp('1);
		write_zone(EU_ZONE_HI);
		send_stamp(32'd4102444800); // 1 january 2100
		send_stamp(32'd4102444799);
		write_zone(HOUR_SECONDS);
		send_stamp(32'd1711846800);
		send_stamp(32'd4291747200); // 1 january 2106
	endtask

	// offsets just outside the rule ranges and the register extremes
	task automatic test_other_offsets();
		int zones [8];
		zones = '{US_ZONE_LO - 1, US_ZONE_HI + 1, EU_ZONE_LO - 1, EU_ZONE_HI + 1,
			ZONE_MIN, ZONE_MAX, -12 * HOUR_SECONDS, 14 * HOUR_SECONDS};
		foreach (zones[i]) begin
			write_zone(zones[i]);
			send_stamp($urandom);
		end
	endtask

	task automatic test_random_windows();
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: write_zone(US_ZONE_LO);
				1: write_zone(EU_ZONE_HI);
				default: write_zone(random_zone());
			endcase
			quiet = (p % 5 == 4);
			for (int i = 0; i < PHASE_STAMPS; i++) begin
				send_stamp(random_stamp());
			end
			quiet = 1'b0;
		end
	endtask

	// timeout
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
		end
		$display("timeout after %0d cycles, %0d windows outstanding", cycle_count,
			pending_windows.size());
		$display("== FAIL ==");
		$finish;
	end

	initial begin : main
		arst_n                       = 1'b0;
		cur_zone                     = 0;
		stamp_gap                    = 0;
		quiet                        = 1'b0;
		stamps_sent                  = 0;
		zone_writes                  = 0;
		cfg_bus.valid               <= 1'b0;
		cfg_bus.zone_offset_seconds <= '0;
		stamp_bus.valid             <= 1'b0;
		stamp_bus.utc_seconds       <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_us_rules();
		test_eu_rules();
		test_other_offsets();
		test_random_windows();

		// drain
		stamp_release();
		while (pending_windows.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d time stamp requests over %0d zone offset writes, %0d windows compared",
			stamps_sent, zone_writes, windows_checked);
		$display("%0d mismatching or unexpected windows", mismatches);
		if (mismatches == 0 && pending_windows.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
